>>> src/cbdj_pkg.sv
package cbdj_pkg;

   // Bus routing codes
   typedef enum logic [2:0] {
      TGT_RAM  = 3'd0,
      TGT_CART = 3'd1,
      TGT_PPU  = 3'd2,
      TGT_APU  = 3'd3,
      TGT_DMA  = 3'd4,
      TGT_PAD  = 3'd5,
      TGT_NONE = 3'd6
   } target_type;

   localparam logic [15:0] PPU_BASE_ADDR   = 16'h2000;
   localparam logic [15:0] APU_BASE_ADDR   = 16'h4000;
   localparam logic [15:0] DMA_ADDR        = 16'h4014;
   localparam logic [15:0] APU_STATUS_ADDR = 16'h4015;
   localparam logic [15:0] PAD_ONE_ADDR    = 16'h4016;
   localparam logic [15:0] PAD_TWO_ADDR    = 16'h4017;
   localparam logic [2:0]  SRAM_PAGE       = 3'b011;   // 0x6000..0x7FFF

   localparam logic [2:0]  PPU_REG_STATUS  = 3'd2;
   localparam logic [2:0]  PPU_REG_OAMADDR = 3'd3;
   localparam logic [2:0]  PPU_REG_SCROLL  = 3'd5;
   localparam logic [2:0]  PPU_REG_ADDR    = 3'd6;

   localparam logic [4:0]  PAD_SIGNATURE_STEP = 5'd19;
   localparam logic [7:0]  STROBE_HIGH        = 8'd1;
   localparam logic [7:0]  STROBE_LOW         = 8'd0;

   typedef struct packed {
      logic        operation;
      logic [15:0] bus_address;
      logic [7:0]  write_data;
      logic [7:0]  pad_one_buttons;
      logic [7:0]  pad_two_buttons;
   } req_type;

   typedef struct packed {
      target_type  target;
      logic [15:0] mapped_address;
      logic [2:0]  ppu_register;
      logic        save_ram_write;
      logic        pad_read_bit;
      logic        strobe_cleared;
   } rsp_type;

   // Joypad port commands from the decoder
   typedef struct packed {
      logic       read_one;
      logic       read_two;
      logic       strobe_write;
      logic [7:0] strobe_data;
   } pad_ctl_type;

endpackage

>>> src/cpu_bus_decode_with_joypad.sv
// A request beat passes through the input register, then the result register.
// Throughput: one access per cycle while the output is not stalled; decode and pad index update fit in one stage.
// Reset (synchronous, active high) empties both stages and clears both pad
// read indices and the strobe memory.
module cpu_bus_decode_with_joypad #(
   parameter int RAM_ADDR_BITS       = 11,
   parameter int PAD_SEQUENCE_LENGTH = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cbdj_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cbdj_pkg::rsp_type rsp_payload
);

   // Stage 1: captured request beat
   cbdj_pkg::req_type req_ff, req_in;
   logic              req_valid_ff, req_valid_in;

   // Stage 2: finished response beat
   cbdj_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic req_take;    // request beat accepted
   logic stage_open;  // result register can take a new beat
   logic advance;     // stage 1 moves into stage 2, state commits

   cbdj_pkg::target_type  dec_target;
   logic [15:0]           dec_mapped;
   logic [2:0]            dec_ppu_reg;
   logic                  dec_sram_wr;
   cbdj_pkg::pad_ctl_type pad_ctl;
   logic                  pad_bit;
   logic                  pad_cleared;

   assign stage_open = !rsp_valid_ff || rsp_ready;
   assign advance    = req_valid_ff && stage_open;
   // Input side frees up as soon as stage 1 drains in the same cycle
   assign req_ready  = !req_valid_ff || stage_open;
   assign req_take   = req_valid && req_ready;

   cbdj_decode #(
      .RAM_ADDR_BITS (RAM_ADDR_BITS)
   ) u_decode (
      .req            (req_ff),
      .target         (dec_target),
      .mapped_address (dec_mapped),
      .ppu_register   (dec_ppu_reg),
      .save_ram_write (dec_sram_wr),
      .pad_ctl        (pad_ctl)
   );

   // Pad indices commit only when the beat actually leaves stage 1
   cbdj_pad_port #(
      .PAD_SEQUENCE_LENGTH (PAD_SEQUENCE_LENGTH)
   ) u_pad_port (
      .clock           (clock),
      .reset           (reset),
      .update          (advance),
      .pad_ctl         (pad_ctl),
      .pad_one_buttons (req_ff.pad_one_buttons),
      .pad_two_buttons (req_ff.pad_two_buttons),
      .pad_read_bit    (pad_bit),
      .strobe_cleared  (pad_cleared)
   );

   always_comb begin
      req_in       = req_take ? req_payload : req_ff;
      req_valid_in = req_take || (req_valid_ff && !advance);

      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (advance) begin
         rsp_in.target         = dec_target;
         rsp_in.mapped_address = dec_mapped;
         rsp_in.ppu_register   = dec_ppu_reg;
         rsp_in.save_ram_write = dec_sram_wr;
         rsp_in.pad_read_bit   = pad_bit;
         rsp_in.strobe_cleared = pad_cleared;
         rsp_valid_in          = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers, no reset needed
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // A pad serial bit only ever comes back on a joypad access
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.pad_read_bit) |-> (rsp_payload.target == cbdj_pkg::TGT_PAD))
      else $error("pad bit set outside joypad access");

   // Index clear only comes from the strobe port
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.strobe_cleared) |->
         (rsp_payload.target == cbdj_pkg::TGT_PAD && rsp_payload.mapped_address ==
          cbdj_pkg::PAD_ONE_ADDR))
      else $error("strobe clear outside strobe write");

   // Save-RAM write flag must land in cartridge space
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.save_ram_write) |-> (rsp_payload.target == cbdj_pkg::TGT_CART))
      else $error("save-RAM write outside cartridge space");

   // A stalled output must not drop the beat held in stage 1
   assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && rsp_valid_ff && !rsp_ready) |=> req_valid_ff)
      else $error("stage 1 beat lost under output stall");

endmodule

>>> src/cbdj_decode.sv
module cbdj_decode #(
   parameter int RAM_ADDR_BITS = 11
) (
   input  cbdj_pkg::req_type     req,
   output cbdj_pkg::target_type  target,
   output logic [15:0]           mapped_address,
   output logic [2:0]            ppu_register,
   output logic                  save_ram_write,
   output cbdj_pkg::pad_ctl_type pad_ctl
);

   localparam logic [15:0] RAM_MASK = 16'((1 << RAM_ADDR_BITS) - 1);

   logic [15:0] addr;
   logic [2:0]  reg_sel;
   logic        ppu_dead;

   assign addr    = req.bus_address;
   assign reg_sel = addr[2:0];

   // Status is write-ignored; OAM addr, scroll, addr are read-dead
   assign ppu_dead = req.operation ? (reg_sel == cbdj_pkg::PPU_REG_STATUS)
                                   : ((reg_sel == cbdj_pkg::PPU_REG_OAMADDR) ||
                                      (reg_sel == cbdj_pkg::PPU_REG_SCROLL) ||
                                      (reg_sel == cbdj_pkg::PPU_REG_ADDR));

   always_comb begin
      target             = cbdj_pkg::TGT_NONE;
      mapped_address     = 16'h0000;
      ppu_register       = 3'd0;
      save_ram_write     = 1'b0;
      pad_ctl            = '0;
      pad_ctl.strobe_data = req.write_data;

      if (addr < cbdj_pkg::PPU_BASE_ADDR) begin
         target         = cbdj_pkg::TGT_RAM;
         mapped_address = addr & RAM_MASK;
      end else if (addr > cbdj_pkg::PAD_TWO_ADDR) begin
         target         = cbdj_pkg::TGT_CART;
         mapped_address = addr;
         save_ram_write = req.operation && (addr[15:13] == cbdj_pkg::SRAM_PAGE);
      end else if (addr < cbdj_pkg::APU_BASE_ADDR) begin
         if (!ppu_dead) begin
            target         = cbdj_pkg::TGT_PPU;
            ppu_register   = reg_sel;
            mapped_address = cbdj_pkg::PPU_BASE_ADDR | {13'd0, reg_sel};
         end
      end else if (req.operation) begin
         mapped_address = addr;
         if (addr == cbdj_pkg::DMA_ADDR) begin
            target = cbdj_pkg::TGT_DMA;
         end else if (addr == cbdj_pkg::PAD_ONE_ADDR) begin
            target               = cbdj_pkg::TGT_PAD;
            pad_ctl.strobe_write = 1'b1;
         end else begin
            target = cbdj_pkg::TGT_APU;
         end
      end else begin
         if (addr == cbdj_pkg::APU_STATUS_ADDR) begin
            target         = cbdj_pkg::TGT_APU;
            mapped_address = addr;
         end else if (addr == cbdj_pkg::PAD_ONE_ADDR) begin
            target           = cbdj_pkg::TGT_PAD;
            mapped_address   = addr;
            pad_ctl.read_one = 1'b1;
         end else if (addr == cbdj_pkg::PAD_TWO_ADDR) begin
            target           = cbdj_pkg::TGT_PAD;
            mapped_address   = addr;
            pad_ctl.read_two = 1'b1;
         end
      end
   end

endmodule

>>> src/cbdj_pad_port.sv
module cbdj_pad_port #(
   parameter int PAD_SEQUENCE_LENGTH = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  update,
   input  cbdj_pkg::pad_ctl_type pad_ctl,
   input  logic [7:0]            pad_one_buttons,
   input  logic [7:0]            pad_two_buttons,
   output logic                  pad_read_bit,
   output logic                  strobe_cleared
);

   localparam logic [5:0] SEQ_LEN = 6'(PAD_SEQUENCE_LENGTH);

   logic [4:0] pad_one_index_ff, pad_one_index_in;
   logic [4:0] pad_two_index_ff, pad_two_index_in;
   logic       last_strobe_ff, last_strobe_in;

   logic [4:0] pos;
   logic [7:0] buttons;
   logic [5:0] pos_inc;
   logic [4:0] pos_next;

   // One shared shifter; reads of the two ports are exclusive
   assign pos     = pad_ctl.read_two ? pad_two_index_ff : pad_one_index_ff;
   assign buttons = pad_ctl.read_two ? pad_two_buttons : pad_one_buttons;
   assign pos_inc = {1'b0, pos} + 6'd1;
   assign pos_next = (pos_inc >= SEQ_LEN) ? 5'd0 : pos_inc[4:0];

   always_comb begin
      pad_read_bit = 1'b0;
      if (pad_ctl.read_one || pad_ctl.read_two) begin
         if (pos < 5'd8) begin
            pad_read_bit = buttons[pos[2:0]];
         end else begin
            pad_read_bit = (pos == cbdj_pkg::PAD_SIGNATURE_STEP);
         end
      end
   end

   assign strobe_cleared = pad_ctl.strobe_write && last_strobe_ff &&
                           (pad_ctl.strobe_data == cbdj_pkg::STROBE_LOW);

   always_comb begin
      pad_one_index_in = pad_one_index_ff;
      pad_two_index_in = pad_two_index_ff;
      last_strobe_in   = last_strobe_ff;
      if (update) begin
         if (pad_ctl.read_one) begin
            pad_one_index_in = pos_next;
         end
         if (pad_ctl.read_two) begin
            pad_two_index_in = pos_next;
         end
         if (pad_ctl.strobe_write) begin
            last_strobe_in = (pad_ctl.strobe_data == cbdj_pkg::STROBE_HIGH);
            if (strobe_cleared) begin
               pad_one_index_in = 5'd0;
               pad_two_index_in = 5'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_one_index_ff <= 5'd0;
         pad_two_index_ff <= 5'd0;
         last_strobe_ff   <= 1'b0;
      end else begin
         pad_one_index_ff <= pad_one_index_in;
         pad_two_index_ff <= pad_two_index_in;
         last_strobe_ff   <= last_strobe_in;
      end
   end

endmodule

>>> bench/cbdj_checker.sv
module cbdj_checker #(
   parameter int RAM_ADDR_BITS       = 11,
   parameter int PAD_SEQUENCE_LENGTH = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  cbdj_pkg::req_type req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  cbdj_pkg::rsp_type rsp_payload,
   output int                fail_count,
   output int                pending_results,
   output int                results_checked,
   output int                strobe_clears
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [15:0] RAM_MASK = (16'd1 << RAM_ADDR_BITS) - 16'd1;

   // predicted port state
   logic [4:0] pad_one_idx;
   logic [4:0] pad_two_idx;
   logic       strobe_was_high;

   cbdj_pkg::rsp_type decoded_q[$];

   function automatic logic [4:0] next_pad_index(input logic [4:0] idx);
      int step;
      step = int'(idx) + 1;
      if (step >= PAD_SEQUENCE_LENGTH) step = 0;
      return step[4:0];
   endfunction

   function automatic logic pad_serial(input logic [4:0] idx, input logic [7:0] buttons);
      if (idx < 5'd8) return buttons[idx[2:0]];
      return idx == cbdj_pkg::PAD_SIGNATURE_STEP;
   endfunction

   task automatic decode_access(input cbdj_pkg::req_type acc,
                                output cbdj_pkg::rsp_type res);
      logic [15:0] addr;
      logic [2:0]  sel;
      logic        dead;
      addr = acc.bus_address;
      res = '0;
      res.target = cbdj_pkg::TGT_NONE;
      if (addr < cbdj_pkg::PPU_BASE_ADDR) begin
         res.target = cbdj_pkg::TGT_RAM;
         res.mapped_address = addr & RAM_MASK;
      end else if (addr > cbdj_pkg::PAD_TWO_ADDR) begin
         res.target = cbdj_pkg::TGT_CART;
         res.mapped_address = addr;
         res.save_ram_write = acc.operation && (addr[15:13] == cbdj_pkg::SRAM_PAGE);
      end else if (addr < cbdj_pkg::APU_BASE_ADDR) begin
         sel = addr[2:0];
         dead = acc.operation ? (sel == cbdj_pkg::PPU_REG_STATUS)
                              : (sel == cbdj_pkg::PPU_REG_OAMADDR ||
                                 sel == cbdj_pkg::PPU_REG_SCROLL ||
                                 sel == cbdj_pkg::PPU_REG_ADDR);
         if (!dead) begin
            res.target = cbdj_pkg::TGT_PPU;
            res.ppu_register = sel;
            res.mapped_address = cbdj_pkg::PPU_BASE_ADDR + {13'd0, sel};
         end
      end else if (acc.operation) begin
         res.mapped_address = addr;
         if (addr == cbdj_pkg::DMA_ADDR) begin
            res.target = cbdj_pkg::TGT_DMA;
         end else if (addr == cbdj_pkg::PAD_ONE_ADDR) begin
            res.target = cbdj_pkg::TGT_PAD;
            if (acc.write_data == cbdj_pkg::STROBE_LOW && strobe_was_high) begin
               pad_one_idx = '0;
               pad_two_idx = '0;
               res.strobe_cleared = 1'b1;
               strobe_clears++;
            end
            strobe_was_high = (acc.write_data == cbdj_pkg::STROBE_HIGH);
         end else begin
            res.target = cbdj_pkg::TGT_APU;
         end
      end else if (addr == cbdj_pkg::APU_STATUS_ADDR) begin
         res.target = cbdj_pkg::TGT_APU;
         res.mapped_address = addr;
      end else if (addr == cbdj_pkg::PAD_ONE_ADDR) begin
         res.target = cbdj_pkg::TGT_PAD;
         res.mapped_address = addr;
         res.pad_read_bit = pad_serial(pad_one_idx, acc.pad_one_buttons);
         pad_one_idx = next_pad_index(pad_one_idx);
      end else if (addr == cbdj_pkg::PAD_TWO_ADDR) begin
         res.target = cbdj_pkg::TGT_PAD;
         res.mapped_address = addr;
         res.pad_read_bit = pad_serial(pad_two_idx, acc.pad_two_buttons);
         pad_two_idx = next_pad_index(pad_two_idx);
      end
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= 10)
            $display("mismatch on response %0d, %s: expected 0x%0h, got 0x%0h",
                     results_checked, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      cbdj_pkg::rsp_type want;
      if (reset) begin
         pad_one_idx     = '0;
         pad_two_idx     = '0;
         strobe_was_high = 1'b0;
         fail_count      = 0;
         results_checked = 0;
         strobe_clears   = 0;
         decoded_q.delete();
      end else begin
         // response first: the beat accepted on this edge cannot have answered yet
         if (rsp_valid && rsp_ready) begin
            if (decoded_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("response beat with nothing outstanding: 0x%0h", rsp_payload);
            end else begin
               want = decoded_q.pop_front();
               compare_field("target", 16'(want.target), 16'(rsp_payload.target));
               compare_field("mapped_address", want.mapped_address,
                             rsp_payload.mapped_address);
               compare_field("ppu_register", 16'(want.ppu_register),
                             16'(rsp_payload.ppu_register));
               compare_field("save_ram_write", 16'(want.save_ram_write),
                             16'(rsp_payload.save_ram_write));
               compare_field("pad_read_bit", 16'(want.pad_read_bit),
                             16'(rsp_payload.pad_read_bit));
               compare_field("strobe_cleared", 16'(want.strobe_cleared),
                             16'(rsp_payload.strobe_cleared));
               results_checked++;
            end
         end
         if (req_valid && req_ready) begin
            decode_access(req_payload, want);
            decoded_q.push_back(want);
         end
      end
      pending_results = decoded_q.size();
   end

endmodule

>>> bench/cpu_bus_decode_with_joypad_tb.sv
module cpu_bus_decode_with_joypad_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int   RAM_BITS         = 11;
   localparam int   PAD_STEPS        = 24;
   localparam logic OP_READ          = 1'b0;
   localparam logic OP_WRITE         = 1'b1;
   localparam int   LONG_HOLD_CYCLES = 300;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   cbdj_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_ready;
   cbdj_pkg::rsp_type rsp_payload;

   int fail_count;
   int pending_results;
   int results_checked;
   int strobe_clears;

   // idle odds in percent, changed per phase
   int send_idle_pct;
   int recv_idle_pct;
   // request for one long response stall, taken up once by the receiver process
   int long_hold_req;
   int items_sent;

   cpu_bus_decode_with_joypad #(
      .RAM_ADDR_BITS      (RAM_BITS),
      .PAD_SEQUENCE_LENGTH(PAD_STEPS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   cbdj_checker #(
      .RAM_ADDR_BITS      (RAM_BITS),
      .PAD_SEQUENCE_LENGTH(PAD_STEPS)
   ) checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .fail_count     (fail_count),
      .pending_results(pending_results),
      .results_checked(results_checked),
      .strobe_clears  (strobe_clears)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop, far beyond the slowest legal run.
   initial begin
      #400000;
      $display("*** FAILED ***");
      $finish;
   end

   // Response side: random back-pressure, or one long hold when asked for.
   // Changes land on the falling edge so the DUT sees them settled at the rise.
   initial begin
      int hold;
      bit hold_taken;
      hold = 0;
      hold_taken = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req > 0 && !hold_taken) begin
            hold = long_hold_req;
            hold_taken = 1'b1;
         end
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Mostly random buttons, with all-released and all-pressed now and then.
   function automatic logic [7:0] pad_pattern();
      case ($urandom_range(7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // One request beat. Idle gaps come before valid rises; once up, valid and
   // payload hold until the beat is taken. Only one NBA per signal per step.
   task automatic send_access(input logic op, input logic [15:0] addr,
                              input logic [7:0] data);
      cbdj_pkg::req_type item;
      item.operation       = op;
      item.bus_address     = addr;
      item.write_data      = data;
      item.pad_one_buttons = pad_pattern();
      item.pad_two_buttons = pad_pattern();
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // Drop valid and hold off until every outstanding response is back.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_results == 0);
   endtask

   // One access aimed at a random region of the map, weighted toward the
   // busy corners (register windows, APU/pad block, save RAM).
   task automatic send_random_access();
      logic        op;
      logic [15:0] addr;
      logic [7:0]  data;
      op   = 1'($urandom_range(1));
      data = 8'($urandom_range(255));
      case ($urandom_range(9))
         0, 1:    addr = 16'($urandom_range(16'h1FFF));
         2, 3:    addr = cbdj_pkg::PPU_BASE_ADDR + 16'($urandom_range(16'h1FFF));
         4, 5:    addr = cbdj_pkg::APU_BASE_ADDR + 16'($urandom_range(16'h17));
         6:       addr = 16'($urandom_range(16'hFFFF, 16'h4018));
         7:       addr = 16'($urandom_range(16'h7FFF, 16'h6000));
         8: begin
            // stray strobe writes, small values so 0 and 1 show up often
            addr = cbdj_pkg::PAD_ONE_ADDR;
            data = 8'($urandom_range(3));
         end
         default: addr = 16'($urandom_range(16'hFFFF));
      endcase
      send_access(op, addr, data);
   endtask

   // Latch sequence (strobe high, strobe low) followed by up to 30 serial reads,
   // split over the two ports and their 24-step sequences. Sometimes broken: an
   // extra high, a non-0/1 value in between, or unrelated beats mixed in.
   task automatic send_pad_sequence();
      int reads;
      reads = $urandom_range(30, 1);
      if ($urandom_range(3) == 0)
         send_access(OP_WRITE, cbdj_pkg::PAD_ONE_ADDR, cbdj_pkg::STROBE_HIGH);
      send_access(OP_WRITE, cbdj_pkg::PAD_ONE_ADDR, cbdj_pkg::STROBE_HIGH);
      if ($urandom_range(7) == 0)
         send_access(OP_WRITE, cbdj_pkg::PAD_ONE_ADDR, 8'($urandom_range(255, 2)));
      send_access(OP_WRITE, cbdj_pkg::PAD_ONE_ADDR, cbdj_pkg::STROBE_LOW);
      repeat (reads) begin
         if ($urandom_range(9) == 0)
            send_random_access();
         else
            send_access(OP_READ,
                        $urandom_range(1) ? cbdj_pkg::PAD_TWO_ADDR : cbdj_pkg::PAD_ONE_ADDR,
                        8'($urandom_range(255)));
      end
   endtask

   task automatic run_random(input int item_goal);
      while (items_sent < item_goal) begin
         if ($urandom_range(9) < 4) send_pad_sequence();
         else send_random_access();
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_payload   = '0;
      send_idle_pct = 9;
      recv_idle_pct = 75;
      long_hold_req = 0;
      items_sent    = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed: region edges and each corner case of the map ---
      send_access(OP_READ,  16'h0000, 8'h00);       // RAM bottom
      send_access(OP_WRITE, 16'h1FFF, 8'hFF);       // top RAM mirror
      send_access(OP_READ,  16'h0800, 8'h5A);       // first mirror
      send_access(OP_WRITE, 16'h2002, 8'hA5);       // status write, dropped
      send_access(OP_READ,  16'h2002, 8'h00);       // status read is live
      send_access(OP_READ,  16'h2003, 8'h00);       // unreadable PPU regs
      send_access(OP_READ,  16'h2005, 8'h00);
      send_access(OP_READ,  16'h3FFE, 8'h00);
      send_access(OP_WRITE, 16'h3FFF, 8'h12);       // top PPU mirror, reg 7
      send_access(OP_READ,  cbdj_pkg::APU_BASE_ADDR, 8'h00);  // low APU reads go nowhere
      send_access(OP_READ,  cbdj_pkg::DMA_ADDR, 8'h00);
      send_access(OP_WRITE, cbdj_pkg::DMA_ADDR, 8'h02);       // sprite DMA
      send_access(OP_READ,  cbdj_pkg::APU_STATUS_ADDR, 8'h00);
      send_access(OP_WRITE, cbdj_pkg::APU_STATUS_ADDR, 8'h0F);
      send_access(OP_WRITE, cbdj_pkg::PAD_TWO_ADDR, 8'h40);   // frame sequencer write
      send_access(OP_WRITE, cbdj_pkg::PAD_ONE_ADDR, 8'h03);   // odd but not 1: no latch
      send_access(OP_WRITE, cbdj_pkg::PAD_ONE_ADDR, cbdj_pkg::STROBE_LOW);
      send_access(OP_WRITE, cbdj_pkg::PAD_ONE_ADDR, cbdj_pkg::STROBE_HIGH);
      // clears both indices
      send_access(OP_WRITE, cbdj_pkg::PAD_ONE_ADDR, cbdj_pkg::STROBE_LOW);
      send_access(OP_READ,  cbdj_pkg::PAD_ONE_ADDR, 8'h00);
      send_access(OP_READ,  cbdj_pkg::PAD_TWO_ADDR, 8'h00);
      send_access(OP_WRITE, 16'h4018, 8'h77);       // first cartridge address
      send_access(OP_WRITE, 16'h6000, 8'h01);       // save RAM bounds
      send_access(OP_WRITE, 16'h7FFF, 8'h80);
      send_access(OP_WRITE, 16'h8000, 8'h80);       // just past save RAM
      send_access(OP_READ,  16'h6000, 8'h00);       // read: no save flag
      send_access(OP_READ,  16'hFFFF, 8'hFF);

      // --- phase 1: sender mostly busy, receiver mostly stalled ---
      run_random(200);
      drain();

      // --- phase 2: the other way round ---
      send_idle_pct = 75;
      recv_idle_pct = 9;
      run_random(350);
      drain();

      // --- phase 3: no idling, with one long receiver hold at the start so
      //     the pipe fills and req_ready drops while valid stays up ---
      send_idle_pct = 0;
      recv_idle_pct = 0;
      long_hold_req = LONG_HOLD_CYCLES;
      run_random(500);
      drain();

      // settle past the two pipeline stages before the verdict
      repeat (8) @(posedge clock);

      $display("Covered %0d bus accesses over three idle mixes and a %0d-cycle response hold.",
               items_sent, LONG_HOLD_CYCLES);
      $display("%0d responses compared, %0d pad strobe clears seen.",
               results_checked, strobe_clears);
      if (fail_count == 0 && pending_results == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
